// File: hdl/iym_pkg.sv
// shared types, constants and tables for the metropolis spin flip block
// no dependencies
package iym_pkg;

	localparam int SITES      = 1024;
	localparam int SITE_W     = $clog2(SITES);
	localparam int MAX_RADIUS = 512;
	localparam int RMAX       = (MAX_RADIUS < SITES / 2) ? MAX_RADIUS : SITES / 2;
	localparam int RAD_W      = 10;
	localparam int MAG_W      = 12;
	localparam int EXP_CUT    = 12;

	localparam logic [MAG_W-1:0] TOTAL_RESET = MAG_W'(-SITES);

	typedef enum logic [1:0] {
		CFG_BETA   = 2'd0,
		CFG_FIELD  = 2'd1,
		CFG_RATIO  = 2'd2,
		CFG_CUTOFF = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic              op;
		logic [SITE_W-1:0] site;
		logic              spin_value;
		logic [15:0]       uniform;
	} in_t;

	typedef struct packed {
		logic              [SITE_W-1:0] site_out;
		logic                           new_spin;
		logic                           flipped;
		logic signed       [MAG_W-1:0]  magnetization;
	} out_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_LOOK, S_OWN, S_NRD, S_NACC, S_DE, S_MULX,
		S_EXP0, S_HMUL, S_HDIV, S_HUPD, S_EMUL, S_FIN
	} state_t;

	typedef struct packed {
		logic clr;
		logic latch;
		logic look;
		logic own;
		logic nrd;
		logic nacc;
		logic de;
		logic mulx;
		logic exp0;
		logic hmul;
		logic hdiv;
		logic hupd;
		logic emul;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic trial;
		logic rmax_zero;
		logic r_last;
		logic de_le0;
		logic x_big;
		logic j_one;
		logic out_free;
	} sts_t;

	// exp(-k) in Q1.16, rounded
	function automatic logic [16:0] expk(input logic [3:0] k);
		logic [16:0] v;
		unique case (k)
			4'd0:    v = 17'd65536;
			4'd1:    v = 17'd24109;
			4'd2:    v = 17'd8869;
			4'd3:    v = 17'd3263;
			4'd4:    v = 17'd1200;
			4'd5:    v = 17'd442;
			4'd6:    v = 17'd162;
			4'd7:    v = 17'd60;
			4'd8:    v = 17'd22;
			4'd9:    v = 17'd8;
			4'd10:   v = 17'd3;
			4'd11:   v = 17'd1;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	// ceil(2^19 / j): (t * m) >> 19 gives t / j exactly for any 16-bit t
	function automatic logic [19:0] div_recip(input logic [3:0] j);
		logic [19:0] m;
		unique case (j)
			4'd1:    m = 20'd524288;
			4'd2:    m = 20'd262144;
			4'd3:    m = 20'd174763;
			4'd4:    m = 20'd131072;
			4'd5:    m = 20'd104858;
			4'd6:    m = 20'd87382;
			4'd7:    m = 20'd74899;
			4'd8:    m = 20'd65536;
			default: m = 20'd0;
		endcase
		return m;
	endfunction

endpackage

// File: hdl/iym_ctrl.sv
// sequencer for clear sweep, neighbor sum, exponential and result
// depends on iym_pkg
module iym_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  iym_pkg::sts_t sts,
	output logic          in_stall,
	output iym_pkg::cmd_t cmd
);

	iym_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iym_pkg::S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			iym_pkg::S_CLEAR: if (sts.clr_last) state_nx = iym_pkg::S_IDLE;
			iym_pkg::S_IDLE:  if (in_valid) state_nx = iym_pkg::S_LOOK;
			iym_pkg::S_LOOK:  state_nx = iym_pkg::S_OWN;
			iym_pkg::S_OWN: begin
				if (!sts.trial)         state_nx = iym_pkg::S_FIN;
				else if (sts.rmax_zero) state_nx = iym_pkg::S_DE;
				else                    state_nx = iym_pkg::S_NRD;
			end
			iym_pkg::S_NRD:   state_nx = iym_pkg::S_NACC;
			iym_pkg::S_NACC:  state_nx = sts.r_last ? iym_pkg::S_DE : iym_pkg::S_NRD;
			iym_pkg::S_DE:    state_nx = iym_pkg::S_MULX;
			iym_pkg::S_MULX:  state_nx = sts.de_le0 ? iym_pkg::S_FIN : iym_pkg::S_EXP0;
			iym_pkg::S_EXP0:  state_nx = sts.x_big ? iym_pkg::S_FIN : iym_pkg::S_HMUL;
			iym_pkg::S_HMUL:  state_nx = iym_pkg::S_HDIV;
			iym_pkg::S_HDIV:  state_nx = iym_pkg::S_HUPD;
			iym_pkg::S_HUPD:  state_nx = sts.j_one ? iym_pkg::S_EMUL : iym_pkg::S_HMUL;
			iym_pkg::S_EMUL:  state_nx = iym_pkg::S_FIN;
			iym_pkg::S_FIN:   if (sts.out_free) state_nx = iym_pkg::S_IDLE;
			default:          state_nx = iym_pkg::S_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			iym_pkg::S_CLEAR: cmd.clr = 1'b1;
			iym_pkg::S_IDLE: begin
				in_stall  = 1'b0;
				cmd.latch = in_valid;
			end
			iym_pkg::S_LOOK:  cmd.look = 1'b1;
			iym_pkg::S_OWN:   cmd.own  = 1'b1;
			iym_pkg::S_NRD:   cmd.nrd  = 1'b1;
			iym_pkg::S_NACC:  cmd.nacc = 1'b1;
			iym_pkg::S_DE:    cmd.de   = 1'b1;
			iym_pkg::S_MULX:  cmd.mulx = 1'b1;
			iym_pkg::S_EXP0:  cmd.exp0 = 1'b1;
			iym_pkg::S_HMUL:  cmd.hmul = 1'b1;
			iym_pkg::S_HDIV:  cmd.hdiv = 1'b1;
			iym_pkg::S_HUPD:  cmd.hupd = 1'b1;
			iym_pkg::S_EMUL:  cmd.emul = 1'b1;
			iym_pkg::S_FIN:   cmd.fin  = sts.out_free;
			default:          cmd = '0;
		endcase
	end

endmodule

// File: hdl/iym_dp.sv
// datapath: spin memory, config registers, weight and sum, exponential, output register
// depends on iym_pkg
module iym_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  iym_pkg::cmd_t cmd,
	input  iym_pkg::in_t  in_data,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	input  logic          out_stall,
	output iym_pkg::sts_t sts,
	output logic          out_valid,
	output iym_pkg::out_t out_data
);

	localparam int SW = iym_pkg::SITE_W;

	logic spin_mem [iym_pkg::SITES];
	logic rd_a_s1, rd_b_s1, vhi_s1, vlo_s1;

	logic [15:0] beta_q, field_q, ratio_q;
	logic [iym_pkg::RAD_W-1:0] cutoff_q, rmax_q, r_q;
	logic [SW-1:0] clr_q, site_q;
	logic op_q, sval_q, s_q, acc_q;
	logic [15:0] uni_q, w_q, f_q, t_q;
	logic signed [27:0] sum_q;
	logic signed [29:0] de_q;
	logic [35:0] x_q;
	logic [3:0] k_q, j_q;
	logic [16:0] p_q;
	logic signed [iym_pkg::MAG_W-1:0] total_q;
	logic out_valid_q;
	iym_pkg::out_t out_q;

	logic [SW:0] hi_sum;
	logic hi_ok, lo_ok;
	logic [SW-1:0] addr_a, addr_b, wr_addr;
	logic wr_en, wr_dat, nsp;
	logic [31:0] wprod;
	logic signed [27:0] ta, tb;
	logic signed [29:0] tot;
	logic [43:0] xprod;
	logic [32:0] hprod;
	logic [33:0] eprod;
	logic [19:0] recip;
	logic [35:0] qprod;

	assign hi_sum  = {1'b0, site_q} + (SW+1)'(r_q);
	assign hi_ok   = hi_sum < (SW+1)'(iym_pkg::SITES);
	assign lo_ok   = (SW+1)'(r_q) <= {1'b0, site_q};
	assign addr_a  = cmd.look ? site_q : hi_sum[SW-1:0];
	assign addr_b  = site_q - SW'(r_q);
	assign nsp     = s_q ^ acc_q;
	assign wr_en   = cmd.clr || (cmd.fin && acc_q);
	assign wr_addr = cmd.clr ? clr_q : site_q;
	assign wr_dat  = cmd.clr ? 1'b0 : nsp;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			spin_mem[wr_addr] <= wr_dat;
		end
		rd_a_s1 <= spin_mem[addr_a];
		rd_b_s1 <= spin_mem[addr_b];
		vhi_s1  <= hi_ok;
		vlo_s1  <= lo_ok;
	end

	assign wprod  = w_q * ratio_q;
	assign ta     = (vhi_s1 ? (rd_a_s1 ? 28'sd1 : -28'sd1) : 28'sd0) * $signed({12'd0, w_q});
	assign tb     = (vlo_s1 ? (rd_b_s1 ? 28'sd1 : -28'sd1) : 28'sd0) * $signed({12'd0, w_q});
	assign tot    = $signed({sum_q[27], sum_q, 1'b0})
	              + ((site_q == '0) ? $signed({{5{field_q[15]}}, field_q, 9'd0}) : 30'sd0);
	assign xprod  = beta_q * de_q[27:0];
	assign hprod  = f_q * p_q;
	assign eprod  = iym_pkg::expk(k_q) * p_q;
	assign recip  = iym_pkg::div_recip(j_q);
	assign qprod  = t_q * recip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q   <= 16'd102;
			field_q  <= 16'd512;
			ratio_q  <= 16'd59299;
			cutoff_q <= 10'd100;
		end else if (cfg_we) begin
			unique case (iym_pkg::cfg_idx_t'(cfg_index))
				iym_pkg::CFG_BETA:   beta_q   <= cfg_data;
				iym_pkg::CFG_FIELD:  field_q  <= cfg_data;
				iym_pkg::CFG_RATIO:  ratio_q  <= cfg_data;
				iym_pkg::CFG_CUTOFF: cutoff_q <= cfg_data[iym_pkg::RAD_W-1:0];
				default:             beta_q   <= beta_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			total_q     <= iym_pkg::TOTAL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) clr_q <= clr_q + SW'(1);
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
				if (acc_q) total_q <= total_q + (nsp ? 12'sd2 : -12'sd2);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= in_data.op;
			site_q <= in_data.site;
			sval_q <= in_data.spin_value;
			uni_q  <= in_data.uniform;
			rmax_q <= (cutoff_q > iym_pkg::RAD_W'(iym_pkg::RMAX)) ?
			          iym_pkg::RAD_W'(iym_pkg::RMAX) : cutoff_q;
			r_q    <= iym_pkg::RAD_W'(1);
			w_q    <= ratio_q;
			sum_q  <= '0;
		end
		if (cmd.own) begin
			s_q   <= rd_a_s1;
			acc_q <= rd_a_s1 ^ sval_q;
		end
		if (cmd.nacc) begin
			sum_q <= sum_q + ta + tb;
			w_q   <= wprod[31:16];
			r_q   <= r_q + iym_pkg::RAD_W'(1);
		end
		if (cmd.de) de_q <= s_q ? tot : -tot;
		if (cmd.mulx) begin
			acc_q <= 1'b1;
			x_q   <= xprod[43:8];
		end
		if (cmd.exp0) begin
			acc_q <= 1'b0;
			k_q   <= x_q[19:16];
			f_q   <= x_q[15:0];
			p_q   <= 17'h10000;
			j_q   <= 4'd8;
		end
		if (cmd.hmul) t_q <= hprod[31:16];
		if (cmd.hdiv) t_q <= qprod[34:19];
		if (cmd.hupd) begin
			p_q <= 17'h10000 - {1'b0, t_q};
			j_q <= j_q - 4'd1;
		end
		if (cmd.emul) acc_q <= eprod[33:16] > {2'b0, uni_q};
		if (cmd.fin) begin
			out_q.site_out      <= site_q;
			out_q.new_spin      <= nsp;
			out_q.flipped       <= acc_q;
			out_q.magnetization <= acc_q ? total_q + (nsp ? 12'sd2 : -12'sd2) : total_q;
		end
	end

	always_comb begin
		sts           = '0;
		sts.clr_last  = clr_q == {SW{1'b1}};
		sts.trial     = op_q;
		sts.rmax_zero = rmax_q == '0;
		sts.r_last    = r_q == rmax_q;
		sts.de_le0    = de_q[29] || (de_q == '0);
		sts.x_big     = x_q[35:16] >= 20'(iym_pkg::EXP_CUT);
		sts.j_one     = j_q == 4'd1;
		sts.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: hdl/ising_yukawa_metropolis_flip.sv
// channel   dir  payload              handshake
// in        in   iym_pkg::in_t        in_valid / in_stall
// out       out  iym_pkg::out_t       out_valid / out_stall
// cfg       in   cfg_index, cfg_data  cfg_we
// a write item passes the look, own and finish states; a trial also walks R, the clipped
// cutoff radius: read and accumulate states per radius step on the dual-read spin memory,
// then at most an 8-step exp series, the divide by the step index by reciprocal multiply
// after reset a sweep over all 1024 sites clears the spin memory; no item is taken meanwhile
// a finished result waits in the output register while the next item is accepted
module ising_yukawa_metropolis_flip (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  iym_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output iym_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);

	iym_pkg::cmd_t cmd;
	iym_pkg::sts_t sts;

	iym_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	iym_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.sts       (sts),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

`ifndef ASSERT_OFF
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second transaction taken while busy");
	a_mag_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !out_data.magnetization[0])
		else $error("odd magnetization");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result loaded without returning to idle");
	a_cmd_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("overlapping datapath commands");
`endif

endmodule
